// ===== hw/rtl/cft_pkg.sv =====
// Shared types and character constants for the CSV field tokenizer.
`default_nettype none

package cft_pkg;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Default depth of the queue between front and back
  localparam int unsigned FifoDepthDefault = 4;

  // Parser mode
  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_FIELD = 3'd1,
    MODE_QUOTE = 3'd2,
    MODE_QCR   = 3'd3,
    MODE_CR    = 3'd4
  } mode_e;

  // Token kinds
  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_FIELD  = 3'd1,
    KIND_RECORD = 3'd2,
    KIND_END    = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] fbyte;
  } token_t;

  // One queue entry: the tokens caused by one text byte
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic valid;
    logic full;
  } fifo_stat_t;

endpackage : cft_pkg

`default_nettype wire

// ===== hw/rtl/cft_if.sv =====
// Handshake interfaces for text bytes and for tokens.
`default_nettype none

interface cft_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface : cft_byte_if

interface cft_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] field_byte;
  logic       run_last;

  modport source (output valid, output token_kind, output field_byte, output run_last,
                  input ready);
  modport sink   (input valid, input token_kind, input field_byte, input run_last,
                  output ready);
endinterface : cft_token_if

`default_nettype wire

// ===== hw/rtl/cft_front.sv =====
// Front end: accepts text bytes, runs the parser mode and pushes token entries.
`default_nettype none

module cft_front import cft_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] text_byte_i,
  input  wire fifo_stat_t fifo_stat_i,
  output logic            push_o,
  output entry_t          entry_o
);

  typedef struct packed {
    logic   emit;
    token_t tok;
    mode_e  mode;
    logic   inq;
  } plain_t;

  // Handle a byte inside a field with nothing pending
  function automatic plain_t plain_byte(logic [7:0] c, logic inq);
    plain_t r;
    r.emit      = 1'b1;
    r.tok.kind  = KIND_DATA;
    r.tok.fbyte = c;
    r.mode      = MODE_FIELD;
    r.inq       = inq;
    if (c == CH_NUL) begin
      r.tok = '{kind: KIND_END, fbyte: 8'h00};
      r.mode = MODE_START;
      r.inq  = 1'b0;
    end else if (c == CH_QUOTE) begin
      r.emit = 1'b0;
      r.mode = MODE_QUOTE;
    end else if (c == CH_CR && !inq) begin
      r.emit = 1'b0;
      r.mode = MODE_CR;
    end else if (c == CH_COMMA && !inq) begin
      r.tok  = '{kind: KIND_FIELD, fbyte: 8'h00};
      r.mode = MODE_START;
      r.inq  = 1'b0;
    end
    return r;
  endfunction

  mode_e  mode_q, mode_d;
  logic   inq_q, inq_d;
  logic   accept;
  logic   emit;
  entry_t entry;
  plain_t pb_cur;
  plain_t pb_clr;

  assign in_ready_o = !fifo_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign pb_cur     = plain_byte(text_byte_i, inq_q);
  assign pb_clr     = plain_byte(text_byte_i, 1'b0);

  // Next parser mode
  always_comb begin
    mode_d = mode_q;
    inq_d  = inq_q;
    unique case (mode_q)
      MODE_FIELD: begin
        mode_d = pb_cur.mode;
        inq_d  = pb_cur.inq;
      end
      MODE_QUOTE: begin
        if (text_byte_i == CH_QUOTE) begin
          mode_d = MODE_FIELD;
        end else if (text_byte_i == CH_CR && inq_q) begin
          mode_d = MODE_QCR;
        end else begin
          mode_d = MODE_START;
          inq_d  = 1'b0;
        end
      end
      MODE_QCR: begin
        mode_d = MODE_START;
        inq_d  = 1'b0;
      end
      MODE_CR: begin
        if (text_byte_i == CH_LF) begin
          mode_d = MODE_START;
          inq_d  = 1'b0;
        end else begin
          mode_d = pb_cur.mode;
          inq_d  = pb_cur.inq;
        end
      end
      default: begin
        if (text_byte_i == CH_QUOTE) begin
          mode_d = MODE_FIELD;
          inq_d  = 1'b1;
        end else begin
          mode_d = pb_clr.mode;
          inq_d  = pb_clr.inq;
        end
      end
    endcase
  end

  // Tokens caused by this byte
  always_comb begin
    emit       = 1'b1;
    entry.two  = 1'b0;
    entry.tok0 = '{kind: KIND_ERROR, fbyte: 8'h00};
    entry.tok1 = '{kind: KIND_ERROR, fbyte: 8'h00};
    unique case (mode_q)
      MODE_FIELD: begin
        emit       = pb_cur.emit;
        entry.tok0 = pb_cur.tok;
      end
      MODE_QUOTE: begin
        if (text_byte_i == CH_QUOTE) begin
          entry.tok0 = '{kind: KIND_DATA, fbyte: CH_QUOTE};
        end else if (text_byte_i == CH_NUL) begin
          entry.tok0 = '{kind: KIND_END, fbyte: 8'h00};
        end else if (text_byte_i == CH_COMMA && inq_q) begin
          entry.tok0 = '{kind: KIND_FIELD, fbyte: 8'h00};
        end else if (text_byte_i == CH_CR && inq_q) begin
          emit = 1'b0;
        end
      end
      MODE_QCR: begin
        if (text_byte_i == CH_LF) begin
          entry.tok0 = '{kind: KIND_RECORD, fbyte: 8'h00};
        end else if (text_byte_i == CH_NUL) begin
          entry.tok0 = '{kind: KIND_END, fbyte: 8'h00};
        end
      end
      MODE_CR: begin
        if (text_byte_i == CH_LF) begin
          entry.tok0 = '{kind: KIND_RECORD, fbyte: 8'h00};
        end else begin
          // Release the held CR, then the byte itself
          entry.tok0 = '{kind: KIND_DATA, fbyte: CH_CR};
          entry.two  = pb_cur.emit;
          entry.tok1 = pb_cur.tok;
        end
      end
      default: begin
        emit       = (text_byte_i != CH_QUOTE) && pb_clr.emit;
        entry.tok0 = pb_clr.tok;
      end
    endcase
  end

  assign push_o  = accept && emit;
  assign entry_o = entry;

  // Advance the mode on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      inq_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      inq_q  <= inq_d;
    end
  end

endmodule : cft_front

`default_nettype wire

// ===== hw/rtl/cft_fifo.sv =====
// Short queue of token entries between the front and the back.
`default_nettype none

module cft_fifo import cft_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  input  wire logic   pop_i,
  output entry_t      head_o,
  output fifo_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign do_pop       = pop_i && (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == FullCnt);

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule : cft_fifo

`default_nettype wire

// ===== hw/rtl/cft_back.sv =====
// Back end: splits queue entries into single tokens and holds the output register.
`default_nettype none

module cft_back import cft_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire fifo_stat_t fifo_stat_i,
  input  wire entry_t     head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      token_kind_o,
  output logic [7:0]      field_byte_o,
  output logic            run_last_o
);

  logic   out_valid_q, out_valid_d;
  token_t out_tok_q, out_tok_d;
  logic   out_last_q, out_last_d;
  logic   sub_q, sub_d;
  logic   load;

  assign load = !out_valid_q || out_ready_i;

  // Pick the next token from the head entry
  always_comb begin
    out_valid_d = out_valid_q;
    out_tok_d   = out_tok_q;
    out_last_d  = out_last_q;
    sub_d       = sub_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = fifo_stat_i.valid;
      if (fifo_stat_i.valid) begin
        out_tok_d  = sub_q ? head_i.tok1 : head_i.tok0;
        out_last_d = sub_q || !head_i.two;
        sub_d      = head_i.two && !sub_q;
        pop_o      = sub_q || !head_i.two;
      end
    end
  end

  // Hold the output transaction until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_tok_q  <= out_tok_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign token_kind_o = out_tok_q.kind;
  assign field_byte_o = out_tok_q.fbyte;
  assign run_last_o   = out_last_q;

endmodule : cft_back

`default_nettype wire

// ===== hw/rtl/csv_field_tokenizer.sv =====
// Top level of the CSV field tokenizer.
// Takes one CSV text byte per transaction and returns tokens: data bytes with
// escapes removed, field ends, record ends, end of text and errors, each with
// run_last set on the last token that one byte causes. A byte is taken every
// cycle while the queue between the parser and the output has room; a byte
// causes zero, one or two tokens, and the output register sends at most one
// token per cycle, so sustained input rate is one byte per cycle except where
// two-token bytes (a held CR released before the next byte) or a stalled
// receiver fill the FifoDepth-entry queue; while it is full no byte is taken.
// A token is registered in the queue and then in the output register before it
// is offered at the output. No clearing is needed after reset.
`default_nettype none

module csv_field_tokenizer import cft_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cft_byte_if.sink    text_i,
  cft_token_if.source token_o
);

  fifo_stat_t fifo_stat;
  logic       push;
  logic       pop;
  entry_t     entry;
  entry_t     head;

  cft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (text_i.valid),
    .in_ready_o  (text_i.ready),
    .text_byte_i (text_i.text_byte),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .entry_o     (entry)
  );

  cft_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (fifo_stat)
  );

  cft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_stat_i  (fifo_stat),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (token_o.valid),
    .out_ready_i  (token_o.ready),
    .token_kind_o (token_o.token_kind),
    .field_byte_o (token_o.field_byte),
    .run_last_o   (token_o.run_last)
  );

endmodule : csv_field_tokenizer

`default_nettype wire

// ===== verif/tb_csv_field_tokenizer.sv =====
// Testbench for the CSV field tokenizer: random and directed text against a local tokenizer model.
`timescale 1ns / 1ps

module tb_csv_field_tokenizer import cft_pkg::*;;

  localparam int unsigned IdleLimit      = 2000;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned RandomBytes    = 1325;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] fbyte;
    logic       last;
  } tok_exp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cft_byte_if  text_if ();
  cft_token_if token_if ();

  csv_field_tokenizer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_if),
    .token_o (token_if)
  );

  // Text bytes waiting to be offered, and tokens still owed by the block
  logic [7:0] text_backlog [$];
  tok_exp_t   pending_tokens [$];
  tok_exp_t   step_tokens [$];

  // Tokenizer state as the block should hold it
  mode_e parse_state;
  logic  quoted_field;

  // Idling controls, set per phase of the run
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned long_holds;
  int unsigned bytes_taken;
  int unsigned bytes_queued = 0;
  int unsigned idle_cycles;
  int unsigned mismatches = 0;
  int unsigned kind_count [0:4] = '{default: 0};

  logic [7:0] opening_text [0:24] = '{
    8'hFF, CH_COMMA,
    CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_COMMA,
    CH_QUOTE, CH_NUL,
    8'h62, CH_CR, CH_CR, CH_LF,
    CH_QUOTE, CH_QUOTE, CH_CR, 8'h58,
    8'h63, CH_QUOTE, CH_CR,
    CH_CR, CH_COMMA,
    CH_CR, CH_NUL
  };

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------

  function automatic void add_token(kind_e kind, logic [7:0] ch);
    tok_exp_t t;
    t.kind  = kind;
    t.fbyte = (kind == KIND_DATA) ? ch : 8'h00;
    t.last  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void begin_field();
    parse_state  = MODE_START;
    quoted_field = 1'b0;
  endfunction

  // Byte inside a field with nothing held back
  function automatic void field_char(logic [7:0] ch);
    if (ch == CH_NUL) begin
      begin_field();
      add_token(KIND_END, 8'h00);
    end else if (ch == CH_QUOTE) begin
      parse_state = MODE_QUOTE;
    end else if (ch == CH_CR && !quoted_field) begin
      parse_state = MODE_CR;
    end else if (ch == CH_COMMA && !quoted_field) begin
      begin_field();
      add_token(KIND_FIELD, 8'h00);
    end else begin
      parse_state = MODE_FIELD;
      add_token(KIND_DATA, ch);
    end
  endfunction

  // Work out the tokens one accepted byte causes and queue them
  function automatic void tokenize_byte(logic [7:0] ch);
    step_tokens.delete();
    case (parse_state)
      MODE_FIELD: field_char(ch);
      MODE_QUOTE: begin
        if (ch == CH_QUOTE) begin
          parse_state = MODE_FIELD;
          add_token(KIND_DATA, CH_QUOTE);
        end else if (ch == CH_NUL) begin
          begin_field();
          add_token(KIND_END, 8'h00);
        end else if (ch == CH_COMMA && quoted_field) begin
          begin_field();
          add_token(KIND_FIELD, 8'h00);
        end else if (ch == CH_CR && quoted_field) begin
          parse_state = MODE_QCR;
        end else begin
          begin_field();
          add_token(KIND_ERROR, 8'h00);
        end
      end
      MODE_QCR: begin
        begin_field();
        if (ch == CH_LF) add_token(KIND_RECORD, 8'h00);
        else if (ch == CH_NUL) add_token(KIND_END, 8'h00);
        else add_token(KIND_ERROR, 8'h00);
      end
      MODE_CR: begin
        if (ch == CH_LF) begin
          begin_field();
          add_token(KIND_RECORD, 8'h00);
        end else begin
          // release the held CR, then treat this byte as usual
          add_token(KIND_DATA, CH_CR);
          parse_state = MODE_FIELD;
          field_char(ch);
        end
      end
      default: begin
        quoted_field = 1'b0;
        if (ch == CH_QUOTE) begin
          quoted_field = 1'b1;
          parse_state  = MODE_FIELD;
        end else begin
          field_char(ch);
        end
      end
    endcase
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  function automatic void queue_byte(logic [7:0] ch);
    text_backlog.push_back(ch);
    bytes_queued++;
  endfunction

  // Mostly printable text, with separators and arbitrary non-zero bytes mixed in
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 19))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_COMMA;
      3:       return CH_QUOTE;
      4, 5:    return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  function automatic void queue_field(bit quoted);
    int unsigned len;
    logic [7:0]  ch;
    len = $urandom_range(0, 6);
    if (quoted) queue_byte(CH_QUOTE);
    for (int unsigned i = 0; i < len; i++) begin
      ch = pick_char();
      if (quoted) begin
        queue_byte(ch);
        if (ch == CH_QUOTE) queue_byte(CH_QUOTE);
      end else begin
        while (ch == CH_COMMA || ch == CH_QUOTE) ch = pick_char();
        queue_byte(ch);
      end
    end
    if (quoted) queue_byte(CH_QUOTE);
  endfunction

  function automatic void queue_record();
    int unsigned fields;
    fields = $urandom_range(1, 4);
    for (int unsigned f = 0; f < fields; f++) begin
      queue_field($urandom_range(0, 2) == 0);
      if (f + 1 < fields) queue_byte(CH_COMMA);
    end
    if ($urandom_range(0, 9) == 0) begin
      queue_byte(CH_NUL);
    end else begin
      queue_byte(CH_CR);
      queue_byte(CH_LF);
    end
  endfunction

  // Loose bytes that break whatever sequence is under way
  function automatic void queue_noise();
    int unsigned len;
    len = $urandom_range(1, 8);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       queue_byte(CH_NUL);
        1:       queue_byte(CH_QUOTE);
        2:       queue_byte(CH_COMMA);
        3:       queue_byte(CH_CR);
        4:       queue_byte(CH_LF);
        default: queue_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void queue_text(int unsigned count);
    int unsigned target;
    target = bytes_queued + count;
    while (bytes_queued < target) begin
      if ($urandom_range(0, 9) < 8) queue_record();
      else queue_noise();
    end
  endfunction

  task automatic wait_drained();
    while (text_backlog.size() != 0 || text_if.valid || pending_tokens.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued bytes, hold each until taken, idle in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_if.valid     <= 1'b0;
      text_if.text_byte <= 8'h00;
      send_gap          <= 0;
    end else if (text_if.valid && !text_if.ready) begin
      // hold the current offer
    end else if (send_gap > 0) begin
      text_if.valid <= 1'b0;
      send_gap      <= send_gap - 1;
    end else if (text_backlog.size() > 0) begin
      text_if.valid     <= 1'b1;
      text_if.text_byte <= text_backlog.pop_front();
      if ($urandom_range(0, 99) < send_gap_pct) send_gap <= $urandom_range(1, 18);
    end else begin
      text_if.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus long hold-offs that fill the block
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_if.ready <= 1'b0;
      recv_gap       <= 0;
      long_holds     <= 0;
    end else if (recv_gap > 0) begin
      token_if.ready <= 1'b0;
      recv_gap       <= recv_gap - 1;
    end else if (long_holds < 2 && bytes_taken >= 200 + 700 * long_holds) begin
      token_if.ready <= 1'b0;
      recv_gap       <= LongHoldCycles - 1;
      long_holds     <= long_holds + 1;
    end else if ($urandom_range(0, 99) < recv_gap_pct) begin
      token_if.ready <= 1'b0;
      recv_gap       <= $urandom_range(0, 17);
    end else begin
      token_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each byte transaction, check each token transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    tok_exp_t exp_tok;
    if (!rst_ni) begin
      begin_field();
      bytes_taken <= 0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        tokenize_byte(text_if.text_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (token_if.valid && token_if.ready) begin
        if (token_if.token_kind <= 3'd4) kind_count[token_if.token_kind]++;
        if (pending_tokens.size() == 0) begin
          $error("token with none expected: kind %0d byte 0x%02h last %0b",
                 token_if.token_kind, token_if.field_byte, token_if.run_last);
          mismatches++;
        end else begin
          exp_tok = pending_tokens.pop_front();
          if (token_if.token_kind !== exp_tok.kind) begin
            $error("token_kind: expected %0d, got %0d", exp_tok.kind, token_if.token_kind);
            mismatches++;
          end
          if (token_if.field_byte !== exp_tok.fbyte) begin
            $error("field_byte: expected 0x%02h, got 0x%02h",
                   exp_tok.fbyte, token_if.field_byte);
            mismatches++;
          end
          if (token_if.run_last !== exp_tok.last) begin
            $error("run_last: expected %0b, got %0b", exp_tok.last, token_if.run_last);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((text_if.valid && text_if.ready) || (token_if.valid && token_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $error("no transaction for %0d cycles, %0d tokens outstanding",
             idle_cycles, pending_tokens.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed text: byte extremes, quoting, held CR and error paths
    send_gap_pct = 20;
    recv_gap_pct = 20;
    foreach (opening_text[i]) queue_byte(opening_text[i]);
    wait_drained();

    // Random text with moderate idling on both sides
    send_gap_pct = 15;
    recv_gap_pct = 15;
    queue_text(500);
    // sender pauses until every token is back
    wait_drained();

    // Heavy receiver stalls against a busy sender
    send_gap_pct = 3;
    recv_gap_pct = 40;
    queue_text(500);

    // Final stretch at full rate
    while (text_backlog.size() != 0) @(negedge clk_i);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    queue_text(RandomBytes - 1000);
    wait_drained();
    repeat (10) @(negedge clk_i);

    $display("Tokenized %0d text bytes across directed, stalled and full-rate phases.",
             bytes_taken);
    $display("Tokens: %0d data, %0d field ends, %0d record ends, %0d ends of text, %0d errors.",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule : tb_csv_field_tokenizer

// ===== files.f =====
hw/rtl/cft_pkg.sv
hw/rtl/cft_if.sv
hw/rtl/cft_front.sv
hw/rtl/cft_fifo.sv
hw/rtl/cft_back.sv
hw/rtl/csv_field_tokenizer.sv
verif/tb_csv_field_tokenizer.sv
